/* src/u256_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u256_pkg
// Shared types and constants of the 256-bit unsigned arithmetic unit.
// ----------------------------------------------------------------------------
package u256_pkg;

    localparam int OP_WIDTH   = 256;
    localparam int LIMB_WIDTH = 32;
    localparam int CNT_WIDTH  = 9;

    typedef enum logic [2:0] {
        CMD_SHL    = 3'd0,
        CMD_SHR    = 3'd1,
        CMD_MULS   = 3'd2,
        CMD_MUL    = 3'd3,
        CMD_DIV    = 3'd4,
        CMD_CMP    = 3'd5,
        CMD_BITLEN = 3'd6,
        CMD_NONE   = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic clear;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
    } dp_stat_t;

endpackage : u256_pkg
`default_nettype wire

/* src/uint256_arithmetic_unit_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uint256_arithmetic_unit_core
// 256-bit unsigned ALU: shifts, multiplies, divide, compare, bit length.
// ----------------------------------------------------------------------------
// channel  direction  contents
// s_axis   in         command, operand A, operand B, shift amount
// m_axis   out        result words, order, bit length, divide error
//
// One transaction at a time. Divide takes 256 steps, bit length up to 256,
// shifts one step per bit (at least one, two for an amount of 256 or more,
// stopping early once the value is zero), full multiply 36 steps (one 32x32
// multiply-accumulate per cycle), short multiply 8, compare 1. The sequencer
// accepts in idle, steps until the registered last flag, then offers the result.
// The result is held until m_axis_tready. rst_n clears the sequencer.
// ----------------------------------------------------------------------------
module uint256_arithmetic_unit_core
    import u256_pkg::*;
#(
    parameter int LIMB_COUNT = 8
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // command[2:0], opa_word0..3[258:3], opb_word0..3[514:259],
    // shift_amount[523:515], zero pad to 528
    input  wire logic [527:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_word0..3[255:0], order[257:256], bit_length[266:258],
    // divide_error[267], zero pad to 272
    output logic      [271:0] m_axis_tdata
);

    dp_cmd_t              dp_cmd;
    dp_stat_t             dp_stat;
    logic [OP_WIDTH-1:0]  res;
    logic [1:0]           order;
    logic [CNT_WIDTH-1:0] bit_length;
    logic                 divide_error;

    u256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    u256_dpath #(.LIMB_COUNT(LIMB_COUNT)) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat),
        .command      (s_axis_tdata[2:0]),
        .opa          (s_axis_tdata[258:3]),
        .opb          (s_axis_tdata[514:259]),
        .shift_amount (s_axis_tdata[523:515]),
        .res          (res),
        .order        (order),
        .bit_length   (bit_length),
        .divide_error (divide_error)
    );

    assign m_axis_tdata = {4'b0, divide_error, bit_length, order, res};

endmodule : uint256_arithmetic_unit_core
`default_nettype wire

/* src/u256_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u256_ctrl
// Sequencer: accepts a transaction, steps the datapath, hands out the result.
// ----------------------------------------------------------------------------
module u256_ctrl
    import u256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output dp_cmd_t       dp_cmd,
    input  wire dp_stat_t dp_stat
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (dp_stat.last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        dp_cmd.load  = 1'b0;
        dp_cmd.step  = 1'b0;
        dp_cmd.clear = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                dp_cmd.load = in_valid;
            end
            ST_RUN:  dp_cmd.step = 1'b1;
            ST_DONE: out_valid = 1'b1;
            default: dp_cmd.clear = 1'b1;
        endcase
    end

endmodule : u256_ctrl
`default_nettype wire

/* src/u256_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u256_dpath
// Operand registers, one 32x32 multiplier, a 257-bit subtractor and a
// step counter. Every command runs as a sequence of steps.
// ----------------------------------------------------------------------------
module u256_dpath
    import u256_pkg::*;
#(
    parameter int LIMB_COUNT = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_cmd_t               dp_cmd,
    output dp_stat_t                   dp_stat,
    input  wire logic [2:0]            command,
    input  wire logic [OP_WIDTH-1:0]   opa,
    input  wire logic [OP_WIDTH-1:0]   opb,
    input  wire logic [CNT_WIDTH-1:0]  shift_amount,
    output logic      [OP_WIDTH-1:0]   res,
    output logic      [1:0]            order,
    output logic      [CNT_WIDTH-1:0]  bit_length,
    output logic                       divide_error
);

    localparam int NBITS = LIMB_COUNT * LIMB_WIDTH;
    localparam int LW    = (LIMB_COUNT > 1) ? $clog2(LIMB_COUNT) : 1;

    logic [OP_WIDTH-1:0]   a_reg, b_reg, r_reg;
    logic [NBITS:0]        rem_reg;
    logic [CNT_WIDTH-1:0]  amt_reg, cnt_reg, blen_reg;
    logic [2:0]            cmd_reg;
    logic [LW-1:0]         i_reg, j_reg;
    logic [LIMB_WIDTH-1:0] carry_reg;
    logic [1:0]            ord_reg;
    logic                  err_reg, last_reg;

    logic [OP_WIDTH-1:0]   mask;
    logic [LIMB_WIDTH-1:0] mul_a, mul_b, acc_limb;
    logic [63:0]           prod;
    logic [NBITS:0]        rem_sh, rem_sub;
    logic [LW:0]           k_idx;
    logic                  b_zero;

    assign mask = (OP_WIDTH)'({NBITS{1'b1}});
    assign b_zero = (b_reg == '0);

    // multiply-accumulate on limb j of A and limb i of B (limb 0 of B for the short multiply) into limb i+j
    assign k_idx    = (LW+1)'(i_reg) + (LW+1)'(j_reg);
    assign mul_a    = a_reg[j_reg*LIMB_WIDTH +: LIMB_WIDTH];
    assign mul_b    = (cmd_reg == CMD_MULS) ? b_reg[LIMB_WIDTH-1:0]
                                           : b_reg[i_reg*LIMB_WIDTH +: LIMB_WIDTH];
    assign acc_limb = (cmd_reg == CMD_MULS) ? '0
                                           : r_reg[k_idx[LW-1:0]*LIMB_WIDTH +: LIMB_WIDTH];
    assign prod     = mul_a * mul_b + 64'(acc_limb) + 64'(carry_reg);

    assign rem_sh  = {rem_reg[NBITS-1:0], a_reg[NBITS-1]};
    assign rem_sub = rem_sh - (NBITS+1)'(b_reg[NBITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
        end
        else if (dp_cmd.load || dp_cmd.clear)
        begin
            last_reg <= 1'b0;
        end
        else if (dp_cmd.step)
        begin
            case (cmd_reg)
                CMD_SHL, CMD_SHR: last_reg <= (amt_reg <= 9'd1) || (cnt_reg == 9'd0);
                CMD_MULS:         last_reg <= (j_reg == LW'(LIMB_COUNT - 1));
                CMD_MUL:          last_reg <= (j_reg == LW'(LIMB_COUNT - 1))
                                              && (k_idx == (LW+1)'(LIMB_COUNT - 1))
                                              || (LIMB_COUNT == 1);
                CMD_DIV:          last_reg <= b_zero || (cnt_reg == 9'd1);
                CMD_BITLEN:       last_reg <= (cnt_reg == 9'd1) || a_reg[NBITS-1];
                default:          last_reg <= 1'b1;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg   <= command;
            a_reg     <= opa & mask;
            b_reg     <= opb & mask;
            rem_reg   <= '0;
            amt_reg   <= shift_amount;
            cnt_reg   <= (command == CMD_DIV || command == CMD_BITLEN)
                         ? CNT_WIDTH'(NBITS) : CNT_WIDTH'(NBITS - 1);
            i_reg     <= '0;
            j_reg     <= '0;
            carry_reg <= '0;
            ord_reg   <= '0;
            err_reg   <= 1'b0;
            blen_reg  <= '0;
            if ((command == CMD_SHL || command == CMD_SHR)
                && shift_amount < CNT_WIDTH'(NBITS))
            begin
                r_reg <= opa & mask;
            end
            else
            begin
                r_reg <= '0;
            end
        end
        else if (dp_cmd.step && !last_reg)
        begin
            case (cmd_reg)
                CMD_SHL:
                begin
                    // one bit a cycle, amount counts down
                    if (amt_reg != '0 && r_reg != '0)
                    begin
                        r_reg   <= {r_reg[OP_WIDTH-2:0], 1'b0} & mask;
                        amt_reg <= amt_reg - 9'd1;
                    end
                    else
                    begin
                        amt_reg <= '0;
                    end
                    cnt_reg <= cnt_reg - 9'd1;
                end
                CMD_SHR:
                begin
                    if (amt_reg != '0 && r_reg != '0)
                    begin
                        r_reg   <= {1'b0, r_reg[OP_WIDTH-1:1]};
                        amt_reg <= amt_reg - 9'd1;
                    end
                    else
                    begin
                        amt_reg <= '0;
                    end
                    cnt_reg <= cnt_reg - 9'd1;
                end
                CMD_MULS:
                begin
                    r_reg[j_reg*LIMB_WIDTH +: LIMB_WIDTH] <= prod[31:0];
                    carry_reg <= prod[63:32];
                    j_reg     <= j_reg + LW'(1);
                end
                CMD_MUL:
                begin
                    r_reg[k_idx[LW-1:0]*LIMB_WIDTH +: LIMB_WIDTH] <= prod[31:0];
                    if (k_idx == (LW+1)'(LIMB_COUNT - 1))
                    begin
                        carry_reg <= '0;
                        i_reg     <= '0;
                        j_reg     <= j_reg + LW'(1);
                    end
                    else
                    begin
                        carry_reg <= prod[63:32];
                        i_reg     <= i_reg + LW'(1);
                    end
                end
                CMD_DIV:
                begin
                    if (b_zero)
                    begin
                        err_reg <= 1'b1;
                    end
                    else
                    begin
                        a_reg <= {a_reg[OP_WIDTH-2:0], 1'b0};
                        if (!rem_sub[NBITS])
                        begin
                            rem_reg <= rem_sub;
                            r_reg   <= {r_reg[OP_WIDTH-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            r_reg   <= {r_reg[OP_WIDTH-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 9'd1;
                    end
                end
                CMD_CMP:
                begin
                    if (a_reg < b_reg)
                    begin
                        ord_reg <= 2'b11;
                    end
                    else if (a_reg > b_reg)
                    begin
                        ord_reg <= 2'b01;
                    end
                end
                CMD_BITLEN:
                begin
                    // scan from the top; the count left is the length
                    if (a_reg[NBITS-1])
                    begin
                        blen_reg <= cnt_reg;
                    end
                    else
                    begin
                        a_reg   <= {a_reg[OP_WIDTH-2:0], 1'b0};
                        cnt_reg <= cnt_reg - 9'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign dp_stat.last = last_reg;
    assign res          = r_reg & mask;
    assign order        = ord_reg;
    assign bit_length   = blen_reg;
    assign divide_error = err_reg;

endmodule : u256_dpath
`default_nettype wire

/* tb/u256_result_checker.sv */
// ----------------------------------------------------------------------------
// u256_result_checker
// Watches both stream channels of the 256-bit arithmetic unit, computes the
// expected result of every accepted command and compares it field by field.
// ----------------------------------------------------------------------------
module u256_result_checker
    import u256_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [527:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [271:0] m_axis_tdata,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic         divide_error;
        logic [8:0]   bit_length;
        logic [1:0]   order;
        logic [255:0] number;
    } alu_result_t;

    alu_result_t expected_results[$];

    function automatic logic [8:0] highest_bit(logic [255:0] a);
        logic [8:0] n;
        n = '0;
        for (int i = 0; i < 256; i++)
            if (a[i])
                n = 9'(i + 1);
        return n;
    endfunction

    // restoring shift-subtract division, quotient only
    function automatic logic [255:0] quotient(logic [255:0] a, logic [255:0] b);
        logic [256:0] r;
        logic [255:0] q;
        r = '0;
        q = '0;
        for (int i = 255; i >= 0; i--)
        begin
            r = {r[255:0], a[i]};
            if (r >= {1'b0, b})
            begin
                r = r - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic alu_result_t compute_result(logic [527:0] d);
        alu_result_t  res;
        cmd_t         cmd;
        logic [255:0] a, b;
        logic [8:0]   amt;
        res = '0;
        cmd = cmd_t'(d[2:0]);
        a   = d[258:3];
        b   = d[514:259];
        amt = d[523:515];
        case (cmd)
            CMD_SHL:    res.number = (amt >= 256) ? '0 : a << amt;
            CMD_SHR:    res.number = (amt >= 256) ? '0 : a >> amt;
            CMD_MULS:   res.number = a * {224'd0, b[31:0]};
            CMD_MUL:    res.number = a * b;
            CMD_DIV:
            begin
                if (b == '0)
                    res.divide_error = 1'b1;
                else
                    res.number = quotient(a, b);
            end
            CMD_CMP:    res.order = (a < b) ? 2'b11 : (a > b) ? 2'b01 : 2'b00;
            CMD_BITLEN: res.bit_length = highest_bit(a);
            default:    res = '0;
        endcase
        return res;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        alu_result_t want, got;
        if (!rst_n)
        begin
            errors <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(compute_result(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[267:0];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.number !== want.number)
                        $display("%0t: result number expected %h actual %h",
                                 $time, want.number, got.number);
                    if (got.order !== want.order)
                        $display("%0t: order expected %h actual %h",
                                 $time, want.order, got.order);
                    if (got.bit_length !== want.bit_length)
                        $display("%0t: bit length expected %0d actual %0d",
                                 $time, want.bit_length, got.bit_length);
                    if (got.divide_error !== want.divide_error)
                        $display("%0t: divide error expected %b actual %b",
                                 $time, want.divide_error, got.divide_error);
                    if (got !== want)
                        errors <= errors + 1;
                end
            end
        end
    end

endmodule : u256_result_checker

/* tb/tb_uint256_arithmetic_unit_core.sv */
// ----------------------------------------------------------------------------
// tb_uint256_arithmetic_unit_core
// Drives directed and random commands into the 256-bit arithmetic unit with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_uint256_arithmetic_unit_core
    import u256_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1800;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [527:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [271:0] m_axis_tdata;
    int           errors;
    int           pending;
    logic         hold_off;

    uint256_arithmetic_unit_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    u256_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .errors        (errors),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [255:0] random_operand();
        logic [255:0] v;
        int kind;
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(0, 9);
        case (kind)
            0: v = '0;
            1: v = '1;
            2: v = v >> $urandom_range(0, 255);
            3: v = v >> $urandom_range(128, 255);
            4: v = 256'd1 << $urandom_range(0, 255);
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [527:0] pack_item(cmd_t cmd, logic [255:0] a, logic [255:0] b,
                                               logic [8:0] amt);
        return {4'd0, amt, b, a, cmd};
    endfunction

    // one transaction, holding tvalid until accepted
    task automatic send_item(logic [527:0] item);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random();
        cmd_t         cmd;
        logic [255:0] a, b;
        logic [8:0]   amt;
        cmd = cmd_t'($urandom_range(0, 7));
        a   = random_operand();
        b   = random_operand();
        if ($urandom_range(0, 3) == 0)
            b = a;
        if ($urandom_range(0, 4) == 0)
            amt = 9'($urandom_range(256, 511));
        else
            amt = 9'($urandom_range(0, 255));
        send_item(pack_item(cmd, a, b, amt));
    endtask

    // receiver: random stall pattern, with a long hold-off on request
    initial
    begin
        int mode;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else
            begin
                mode = $urandom_range(0, 9);
                m_axis_tready <= (mode < 4) ? 1'b1 : ($urandom_range(0, 2) != 0);
            end
        end
    end

    initial
    begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [255:0] max_val;
        int burst;
        max_val = '1;
        hold_off      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, the special cases
        send_item(pack_item(CMD_SHL, max_val, '0, 9'd0));
        send_item(pack_item(CMD_SHL, max_val, '0, 9'd255));
        send_item(pack_item(CMD_SHL, max_val, '0, 9'd256));
        send_item(pack_item(CMD_SHR, max_val, '0, 9'd511));
        send_item(pack_item(CMD_SHR, max_val, '0, 9'd33));
        send_item(pack_item(CMD_MULS, max_val, max_val, 9'd0));
        send_item(pack_item(CMD_MULS, max_val, '0, 9'd0));
        send_item(pack_item(CMD_MUL, max_val, max_val, 9'd0));
        send_item(pack_item(CMD_MUL, '0, max_val, 9'd0));
        send_item(pack_item(CMD_DIV, max_val, '0, 9'd0));
        send_item(pack_item(CMD_DIV, max_val, 256'd1, 9'd0));
        send_item(pack_item(CMD_DIV, max_val, max_val, 9'd0));
        send_item(pack_item(CMD_DIV, 256'd5, max_val, 9'd0));
        send_item(pack_item(CMD_CMP, max_val, max_val, 9'd0));
        send_item(pack_item(CMD_CMP, '0, max_val, 9'd0));
        send_item(pack_item(CMD_CMP, max_val, '0, 9'd0));
        send_item(pack_item(CMD_BITLEN, '0, '0, 9'd0));
        send_item(pack_item(CMD_BITLEN, max_val, '0, 9'd0));
        send_item(pack_item(CMD_BITLEN, 256'd1, '0, 9'd0));
        send_item(pack_item(CMD_NONE, max_val, max_val, 9'd511));
        s_axis_tvalid <= 1'b0;

        // long receiver hold-off while the sender keeps offering
        hold_off <= 1'b1;
        fork
            begin
                repeat (3) send_random();
                s_axis_tvalid <= 1'b0;
            end
            begin
                repeat (2000) @(posedge clk);
                hold_off <= 1'b0;
            end
        join

        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++)
                send_random();
            s_axis_tvalid <= 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b0;

        // let the last accepted transaction reach the checker's queue, then drain it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : tb_uint256_arithmetic_unit_core
